>>> hdl/kvt_pkg.sv
`default_nettype none
package kvt_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned SUM_W     = 38;
  localparam int unsigned ENTRY_W   = KEY_W + VAL_W;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_DELETE,
    CMD_TOTAL,
    CMD_LIST
  } kvt_cmd_t;

  typedef enum logic [2:0] {
    ST_ADDED,
    ST_UPDATED,
    ST_FULL,
    ST_DELETED,
    ST_NOTFOUND,
    ST_TOTAL,
    ST_ENTRY,
    ST_EMPTY
  } kvt_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_CHK,
    S_MV_RD,
    S_MV_WR
  } kvt_state_t;

  typedef struct packed {
    kvt_cmd_t                 command;
    logic signed [KEY_W-1:0]  key;
    logic        [VAL_W-1:0]  value;
  } kvt_in_t;

  typedef struct packed {
    kvt_status_t              status;
    logic signed [KEY_W-1:0]  out_key;
    logic        [VAL_W-1:0]  out_value;
    logic        [SUM_W-1:0]  sum;
    logic                     last;
  } kvt_out_t;

endpackage
`default_nettype wire

>>> hdl/kvt_ram.sv
`default_nettype none
module kvt_ram #(
  parameter  int unsigned WIDTH = kvt_pkg::ENTRY_W,
  parameter  int unsigned DEPTH = kvt_pkg::DEPTH_DEF,
  localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/keyed_value_table.sv
`default_nettype none
// Keyed value table: up to DEPTH key/value pairs kept packed in insertion order.
// Input channel: in_data (command, key, value) is taken on a rising edge with
// start high and busy low. busy stays high while an item is being worked on.
// Result channel: out_valid marks one result word on out_data for exactly one
// cycle; the receiver cannot stall it. last is set on the final word of an item.
// List gives one word per stored entry (one empty word on an empty table);
// every other command gives one word.
// All entries sit in one single-port-read RAM; each entry is read in an S_RD
// state (address) followed by an S_CHK state (compare). Add and delete walk up
// to the matching slot, total and list walk all filled slots. A delete hit
// then moves each later entry down one slot, by an S_MV_RD state (read) and an
// S_MV_WR state (write) per entry. Commands that need no walk (add to an empty or
// full table, anything on an empty table) answer in the cycle after acceptance
// with busy staying low.
// Reset (rst_n low, synchronous) empties the table at once; RAM contents are
// left as they are and are never read past the fill count.
module keyed_value_table #(
  parameter int unsigned DEPTH = kvt_pkg::DEPTH_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire kvt_pkg::kvt_in_t in_data,
  output logic                  out_valid,
  output kvt_pkg::kvt_out_t     out_data
);

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned KW = kvt_pkg::KEY_W;
  localparam int unsigned VW = kvt_pkg::VAL_W;
  localparam int unsigned SW = kvt_pkg::SUM_W;
  localparam int unsigned EW = kvt_pkg::ENTRY_W;

  kvt_pkg::kvt_state_t state_r, state_nxt;
  kvt_pkg::kvt_cmd_t   cmd_r, cmd_nxt;
  logic [CW-1:0]       fill_r, fill_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [KW-1:0]       key_r, key_nxt;
  logic [VW-1:0]       val_r, val_nxt;
  logic [VW-1:0]       rem_r, rem_nxt;
  logic [SW-1:0]       sum_r, sum_nxt;
  logic                out_valid_r, out_valid_nxt;
  kvt_pkg::kvt_out_t   out_r, out_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [EW-1:0] ram_wdata;
  logic [EW-1:0] ram_rdata;
  logic [KW-1:0] rd_key;
  logic [VW-1:0] rd_val;
  logic [CW-1:0] idx_inc;
  logic          at_end;
  logic          hit;

  kvt_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  assign rd_key  = ram_rdata[EW-1:VW];
  assign rd_val  = ram_rdata[VW-1:0];
  assign idx_inc = idx_r + CW'(1);
  assign at_end  = (idx_inc == fill_r);
  assign hit     = (rd_key == key_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= kvt_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    key_r <= key_nxt;
    val_r <= val_nxt;
    rem_r <= rem_nxt;
    sum_r <= sum_nxt;
    out_r <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    fill_nxt      = fill_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    sum_nxt       = sum_r;
    out_valid_nxt = 1'b0;
    out_nxt       = '0;
    out_nxt.last  = 1'b1;
    ram_we        = 1'b0;
    ram_waddr     = idx_r[AW-1:0];
    ram_wdata     = {key_r, val_r};

    case (state_r)
      kvt_pkg::S_IDLE: begin
        if (start) begin
          cmd_nxt = in_data.command;
          key_nxt = in_data.key;
          val_nxt = in_data.value;
          idx_nxt = '0;
          sum_nxt = '0;
          case (in_data.command)
            kvt_pkg::CMD_ADD: begin
              if (fill_r == CW'(DEPTH)) begin
                out_valid_nxt     = 1'b1;
                out_nxt.status    = kvt_pkg::ST_FULL;
                out_nxt.out_key   = in_data.key;
                out_nxt.out_value = in_data.value;
              end else if (fill_r == '0) begin
                ram_we            = 1'b1;
                ram_waddr         = '0;
                ram_wdata         = {in_data.key, in_data.value};
                fill_nxt          = CW'(1);
                out_valid_nxt     = 1'b1;
                out_nxt.status    = kvt_pkg::ST_ADDED;
                out_nxt.out_key   = in_data.key;
                out_nxt.out_value = in_data.value;
              end else begin
                state_nxt = kvt_pkg::S_RD;
              end
            end
            kvt_pkg::CMD_DELETE: begin
              if (fill_r == '0) begin
                out_valid_nxt   = 1'b1;
                out_nxt.status  = kvt_pkg::ST_NOTFOUND;
                out_nxt.out_key = in_data.key;
              end else begin
                state_nxt = kvt_pkg::S_RD;
              end
            end
            kvt_pkg::CMD_TOTAL: begin
              if (fill_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = kvt_pkg::ST_TOTAL;
              end else begin
                state_nxt = kvt_pkg::S_RD;
              end
            end
            kvt_pkg::CMD_LIST: begin
              if (fill_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_nxt.status = kvt_pkg::ST_EMPTY;
              end else begin
                state_nxt = kvt_pkg::S_RD;
              end
            end
            default: state_nxt = kvt_pkg::S_IDLE;
          endcase
        end
      end

      kvt_pkg::S_RD: state_nxt = kvt_pkg::S_CHK;

      kvt_pkg::S_CHK: begin
        state_nxt = kvt_pkg::S_RD;
        idx_nxt   = idx_inc;
        case (cmd_r)
          kvt_pkg::CMD_ADD: begin
            if (hit || at_end) begin
              ram_we            = 1'b1;
              ram_waddr         = hit ? idx_r[AW-1:0] : fill_r[AW-1:0];
              state_nxt         = kvt_pkg::S_IDLE;
              out_valid_nxt     = 1'b1;
              out_nxt.status    = hit ? kvt_pkg::ST_UPDATED : kvt_pkg::ST_ADDED;
              out_nxt.out_key   = key_r;
              out_nxt.out_value = val_r;
              if (!hit) begin
                fill_nxt = fill_r + CW'(1);
              end
            end
          end
          kvt_pkg::CMD_DELETE: begin
            rem_nxt = rd_val;
            if (hit && at_end) begin
              fill_nxt          = fill_r - CW'(1);
              state_nxt         = kvt_pkg::S_IDLE;
              out_valid_nxt     = 1'b1;
              out_nxt.status    = kvt_pkg::ST_DELETED;
              out_nxt.out_key   = key_r;
              out_nxt.out_value = rd_val;
            end else if (hit) begin
              state_nxt = kvt_pkg::S_MV_RD;
            end else if (at_end) begin
              state_nxt       = kvt_pkg::S_IDLE;
              out_valid_nxt   = 1'b1;
              out_nxt.status  = kvt_pkg::ST_NOTFOUND;
              out_nxt.out_key = key_r;
            end
          end
          kvt_pkg::CMD_TOTAL: begin
            sum_nxt = sum_r + SW'(rd_val);
            if (at_end) begin
              state_nxt      = kvt_pkg::S_IDLE;
              out_valid_nxt  = 1'b1;
              out_nxt.status = kvt_pkg::ST_TOTAL;
              out_nxt.sum    = sum_r + SW'(rd_val);
            end
          end
          kvt_pkg::CMD_LIST: begin
            out_valid_nxt     = 1'b1;
            out_nxt.status    = kvt_pkg::ST_ENTRY;
            out_nxt.out_key   = rd_key;
            out_nxt.out_value = rd_val;
            out_nxt.last      = at_end;
            if (at_end) begin
              state_nxt = kvt_pkg::S_IDLE;
            end
          end
          default: state_nxt = kvt_pkg::S_IDLE;
        endcase
      end

      kvt_pkg::S_MV_RD: state_nxt = kvt_pkg::S_MV_WR;

      kvt_pkg::S_MV_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r[AW-1:0] - AW'(1);
        ram_wdata = ram_rdata;
        if (at_end) begin
          fill_nxt          = fill_r - CW'(1);
          state_nxt         = kvt_pkg::S_IDLE;
          out_valid_nxt     = 1'b1;
          out_nxt.status    = kvt_pkg::ST_DELETED;
          out_nxt.out_key   = key_r;
          out_nxt.out_value = rem_r;
        end else begin
          idx_nxt   = idx_inc;
          state_nxt = kvt_pkg::S_MV_RD;
        end
      end

      default: state_nxt = kvt_pkg::S_IDLE;
    endcase
  end

  assign busy      = (state_r != kvt_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CW'(DEPTH))
    else $error("fill count beyond table depth");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (busy == !out_data.last))
    else $error("busy disagrees with last word");

  a_full_add: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.command == kvt_pkg::CMD_ADD && fill_r == CW'(DEPTH))
    |=> (out_valid && out_data.status == kvt_pkg::ST_FULL))
    else $error("add on full table not reported");

  a_delete_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == kvt_pkg::ST_DELETED) |-> (fill_r == $past(fill_r) - CW'(1)))
    else $error("delete did not shrink table");
`endif

endmodule
`default_nettype wire
